/* hw/rtl/rgb565_blend_upscaler_2p5x_macros.svh */
// Assertion macros shared by the upscaler checker.
`ifndef RGB565_BLEND_UPSCALER_2P5X_MACROS_SVH
`define RGB565_BLEND_UPSCALER_2P5X_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RGBUP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upscaler assertion failed");

// Next-cycle implication, disabled during reset.
`define RGBUP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upscaler assertion failed");

`endif

/* hw/rtl/rgbup_pkg.sv */
// Types, constants and the colour half-sum for the 2.5x RGB565 upscaler.
`timescale 1ns / 1ps
`default_nettype none

package rgbup_pkg;

   // Half-sum masks: drop each channel's low bit, then restore the carry.
   localparam logic [15:0] AVG_MASK   = 16'hF7DE;
   localparam logic [15:0] CARRY_MASK = 16'h0821;

   // Output coordinates advance by five per source pair.
   localparam logic [7:0] PAIR_STEP = 8'd5;
   localparam logic [7:0] MID_ROW_OFFSET = 8'd2;

   // Last column index within one expanded row of five.
   localparam logic [2:0] K_LAST = 3'd4;

   typedef enum logic [1:0] {
      ROW_FIRST,
      ROW_SECOND,
      ROW_THIRD
   } row_sel_type;

   // One odd-column job waiting for the line store read.
   typedef struct packed {
      logic [15:0] lo_a;
      logic [15:0] lo_b;
      logic [7:0]  x0;
      logic [7:0]  y0;
      logic        lower;
   } job_type;

   // Truncating RGB565 average of two pixels.
   function automatic logic [15:0] half_sum(input logic [15:0] p, input logic [15:0] q);
      logic [16:0] r;
      r = 17'((p & AVG_MASK) >> 1) + 17'((q & AVG_MASK) >> 1) + 17'(p & q & CARRY_MASK);
      return r[15:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgbup_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rgbup_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/rgb565_blend_upscaler_2p5x.sv */
// Top level of the 2.5x RGB565 upscaler with averaging.
// Source pixels enter one word per cycle while req_stall is low, in raster
// order. Even columns give no output; each odd column gives ten output words
// on an upper (even) source row and fifteen on a lower (odd) row, in
// output-row order and left to right, with rsp_last_of_run set on the final
// one. The result port emits one word per cycle while rsp_stall is low, so it
// sets the throughput. The upper row is kept as pixel pairs in one line store
// of SRC_WIDTH/2 words of 32 bits; a lower-row odd pixel reads its pair, and
// the averaged row is formed from the registered read data when the job moves
// to the emitter. One odd-column word may wait for the line store read while
// the previous one is still emitting, and even-column words are taken at any
// time. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_blend_upscaler_2p5x #(
   parameter int SRC_WIDTH  = 96,
   parameter int SRC_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_pixel_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_out_x,
   output logic      [7:0]  rsp_out_y,
   output logic      [15:0] rsp_color_out,
   output logic             rsp_last_of_run
);

   localparam int PAIRS = SRC_WIDTH / 2;
   localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int PW    = $clog2(PAIRS + 1);
   localparam int RW    = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
   localparam logic [PW:0]   LAST_COL = (PW + 1)'(SRC_WIDTH - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(SRC_HEIGHT - 1);

   // Input-side counters
   logic [PW-1:0] pair_ff, pair_in;
   logic          phase_ff, phase_in;
   logic [RW-1:0] row_ff, row_in;
   logic [7:0]    x_base_ff, x_base_in;
   logic [7:0]    y_base_ff, y_base_in;
   logic [15:0]   left_ff, left_in;

   // Job waiting for the line store read
   logic              s1_valid_ff, s1_valid_in;
   rgbup_pkg::job_type s1_job_ff, s1_job_in;

   // Emitter
   logic                   em_valid_ff, em_valid_in;
   logic                   em_lower_ff, em_lower_in;
   rgbup_pkg::row_sel_type em_row_ff, em_row_in;
   logic [2:0]             em_k_ff, em_k_in;
   logic [7:0]             em_x0_ff, em_x0_in;
   logic [7:0]             em_x_ff, em_x_in;
   logic [7:0]             em_y_ff, em_y_in;
   logic [15:0]            em_lo_ff [3];
   logic [15:0]            em_lo_in [3];
   logic [15:0]            em_mid_ff [3];
   logic [15:0]            em_mid_in [3];

   logic        col_last;
   logic        req_take;
   logic        odd_take;
   logic        rsp_take;
   logic        em_last;
   logic        em_done;
   logic        s1_move;
   logic        use_mid;
   logic [1:0]  slot;
   logic [31:0] ram_rd_data;
   logic [15:0] up_a;
   logic [15:0] up_b;
   logic [15:0] lo_m;
   logic [15:0] up_m;

   // Handshake and hand-over conditions
   always_comb begin
      col_last = ({pair_ff, phase_ff} == LAST_COL);
      em_last  = (em_k_ff == rgbup_pkg::K_LAST) &&
                 (em_row_ff == (em_lower_ff ? rgbup_pkg::ROW_THIRD : rgbup_pkg::ROW_SECOND));
      rsp_take = em_valid_ff && !rsp_stall;
      em_done  = rsp_take && em_last;
      s1_move  = s1_valid_ff && (!em_valid_ff || em_done);
      req_stall = phase_ff && s1_valid_ff && !s1_move;
      req_take = req_valid && !req_stall;
      odd_take = req_take && phase_ff;
   end

   // Line store: one word per upper-row pixel pair
   rgbup_ram #(
      .WIDTH (32),
      .DEPTH (PAIRS),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (odd_take && !row_ff[0]),
      .wr_addr (pair_ff[AW-1:0]),
      .wr_data ({left_ff, req_pixel_in}),
      .rd_en   (odd_take && row_ff[0]),
      .rd_addr (pair_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Advance column, row and coordinate bases on each accepted word
   always_comb begin
      pair_in   = pair_ff;
      phase_in  = phase_ff;
      row_in    = row_ff;
      x_base_in = x_base_ff;
      y_base_in = y_base_ff;
      left_in   = left_ff;
      if (req_take) begin
         if (!phase_ff) begin
            left_in = req_pixel_in;
         end
         if (col_last) begin
            pair_in   = '0;
            phase_in  = 1'b0;
            x_base_in = '0;
            if (row_ff == LAST_ROW) begin
               row_in    = '0;
               y_base_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
               if (row_ff[0]) begin
                  y_base_in = y_base_ff + rgbup_pkg::PAIR_STEP;
               end
            end
         end else begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               pair_in   = pair_ff + PW'(1);
               x_base_in = x_base_ff + rgbup_pkg::PAIR_STEP;
            end
         end
      end
   end

   // Capture odd-column jobs, drop them once the emitter takes them
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_job_in   = s1_job_ff;
      if (odd_take) begin
         s1_valid_in     = 1'b1;
         s1_job_in.lo_a  = left_ff;
         s1_job_in.lo_b  = req_pixel_in;
         s1_job_in.x0    = x_base_ff;
         s1_job_in.y0    = y_base_ff;
         s1_job_in.lower = row_ff[0];
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // Expand both rows and blend them as the store read returns
   always_comb begin
      up_a = ram_rd_data[31:16];
      up_b = ram_rd_data[15:0];
      lo_m = rgbup_pkg::half_sum(s1_job_ff.lo_a, s1_job_ff.lo_b);
      up_m = rgbup_pkg::half_sum(up_a, up_b);
   end

   // Emitter: load a job, then step through columns and rows
   always_comb begin
      em_valid_in = em_valid_ff;
      em_lower_in = em_lower_ff;
      em_row_in   = em_row_ff;
      em_k_in     = em_k_ff;
      em_x0_in    = em_x0_ff;
      em_x_in     = em_x_ff;
      em_y_in     = em_y_ff;
      em_lo_in    = em_lo_ff;
      em_mid_in   = em_mid_ff;
      if (s1_move) begin
         em_valid_in  = 1'b1;
         em_lower_in  = s1_job_ff.lower;
         em_row_in    = rgbup_pkg::ROW_FIRST;
         em_k_in      = '0;
         em_x0_in     = s1_job_ff.x0;
         em_x_in      = s1_job_ff.x0;
         em_y_in      = s1_job_ff.lower ? s1_job_ff.y0 + rgbup_pkg::MID_ROW_OFFSET
                                        : s1_job_ff.y0;
         em_lo_in[0]  = s1_job_ff.lo_a;
         em_lo_in[1]  = lo_m;
         em_lo_in[2]  = s1_job_ff.lo_b;
         em_mid_in[0] = rgbup_pkg::half_sum(s1_job_ff.lo_a, up_a);
         em_mid_in[1] = rgbup_pkg::half_sum(lo_m, up_m);
         em_mid_in[2] = rgbup_pkg::half_sum(s1_job_ff.lo_b, up_b);
      end else if (rsp_take) begin
         if (em_k_ff == rgbup_pkg::K_LAST) begin
            em_k_in = '0;
            em_x_in = em_x0_ff;
            em_y_in = em_y_ff + 8'd1;
            case (em_row_ff)
               rgbup_pkg::ROW_FIRST:  em_row_in = rgbup_pkg::ROW_SECOND;
               rgbup_pkg::ROW_SECOND: em_row_in = rgbup_pkg::ROW_THIRD;
               default:               em_row_in = rgbup_pkg::ROW_FIRST;
            endcase
            if (em_last) begin
               em_valid_in = 1'b0;
            end
         end else begin
            em_k_in = em_k_ff + 3'd1;
            em_x_in = em_x_ff + 8'd1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff     <= '0;
         phase_ff    <= 1'b0;
         row_ff      <= '0;
         x_base_ff   <= '0;
         y_base_ff   <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
         em_valid_ff <= 1'b0;
         em_row_ff   <= rgbup_pkg::ROW_FIRST;
         em_k_ff     <= '0;
      end else begin
         pair_ff     <= pair_in;
         phase_ff    <= phase_in;
         row_ff      <= row_in;
         x_base_ff   <= x_base_in;
         y_base_ff   <= y_base_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
         em_valid_ff <= em_valid_in;
         em_row_ff   <= em_row_in;
         em_k_ff     <= em_k_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_job_ff   <= s1_job_in;
      em_lower_ff <= em_lower_in;
      em_x0_ff    <= em_x0_in;
      em_x_ff     <= em_x_in;
      em_y_ff     <= em_y_in;
      em_lo_ff    <= em_lo_in;
      em_mid_ff   <= em_mid_in;
   end

   // Pick the colour for the current column of the current row
   always_comb begin
      use_mid = em_lower_ff && (em_row_ff == rgbup_pkg::ROW_FIRST);
      case (em_k_ff)
         3'd0, 3'd1: slot = 2'd0;
         3'd2:       slot = 2'd1;
         default:    slot = 2'd2;
      endcase
   end

   assign rsp_valid       = em_valid_ff;
   assign rsp_out_x       = em_x_ff;
   assign rsp_out_y       = em_y_ff;
   assign rsp_color_out   = use_mid ? em_mid_ff[slot] : em_lo_ff[slot];
   assign rsp_last_of_run = em_last;

endmodule

`default_nettype wire

/* hw/rtl/rgbup_checker.sv */
// Port-level checks for the upscaler, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb565_blend_upscaler_2p5x_macros.svh"

module rgbup_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [15:0] req_pixel_in,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_x,
   input wire logic [7:0]  rsp_out_y,
   input wire logic [15:0] rsp_color_out,
   input wire logic        rsp_last_of_run
);

   logic        rsp_take;
   logic        rsp_mid_run;
   logic [32:0] rsp_word;
   logic [7:0]  x_prev_ff;
   logic        x_step_ok;

   // Result word as seen on the port and its handshake conditions
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign rsp_mid_run = rsp_take && !rsp_last_of_run;
   assign rsp_word    = {rsp_out_x, rsp_out_y, rsp_color_out, rsp_last_of_run};

   // Keep the previous column for the step check
   always_ff @(posedge clock) begin
      x_prev_ff <= rsp_out_x;
   end

   assign x_step_ok = (rsp_out_x == 8'(x_prev_ff + 8'd1)) ||
                      (rsp_out_x == 8'(x_prev_ff - 8'd4));

   // Hold a stalled result word
   `RGBUP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // A run keeps going until its last word
   `RGBUP_ASSERT_NEXT(a_run_continues, clock, reset, rsp_mid_run, rsp_valid)

   // Within a run, step one column right or back to the start of the five
   `RGBUP_ASSERT_NEXT(a_x_step, clock, reset, rsp_mid_run, x_step_ok)

   // Input is held back only while results are still pending
   `RGBUP_ASSERT_NOW(a_stall_busy, clock, reset, req_stall, rsp_valid)

endmodule

bind rgb565_blend_upscaler_2p5x rgbup_checker u_rgbup_checker (.*);

`default_nettype wire

/* verif/tb_rgb565_blend_upscaler_2p5x.sv */
// Self-checking testbench for the 2.5x RGB565 upscaler with averaging.
`timescale 1ns / 1ps

module tb_rgb565_blend_upscaler_2p5x;

   localparam int SRC_W      = 96;
   localparam int SRC_H      = 64;
   localparam int DIR_ROWS   = 24;
   // Rest of the run: the rest of the first row, the lower row and part of the third row.
   localparam int RAND_ITEMS = 220 - DIR_ROWS;
   localparam int HOLD_LEN   = 300;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] colour;
      logic        last;
   } out_pixel_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        fixed_en;
      logic [15:0] fixed_blend;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_pixel_in = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_x;
   logic [7:0]  rsp_out_y;
   logic [15:0] rsp_color_out;
   logic        rsp_last_of_run;

   // Predictor state: copy of the line store, held left pixel and counters
   logic [15:0] upper_line [SRC_W];
   logic [15:0] held_left;
   logic [6:0]  col_idx;
   logic [5:0]  row_idx;

   out_pixel_type pending_pixels [$];
   int            mismatches = 0;
   int            words_seen = 0;
   stim_row_type  directed_rows [DIR_ROWS];

   rgb565_blend_upscaler_2p5x #(
      .SRC_WIDTH  (SRC_W),
      .SRC_HEIGHT (SRC_H)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_color_out   (rsp_color_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Give up after a generous fixed time
   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Per-channel truncating average of two RGB565 colours
   function automatic logic [15:0] blend565(input logic [15:0] p, input logic [15:0] q);
      logic [5:0] rs;
      logic [6:0] gs;
      logic [5:0] bs;
      rs = {1'b0, p[15:11]} + {1'b0, q[15:11]};
      gs = {1'b0, p[10:5]} + {1'b0, q[10:5]};
      bs = {1'b0, p[4:0]} + {1'b0, q[4:0]};
      return {rs[5:1], gs[6:1], bs[5:1]};
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random colour, biased towards black, white and saturated channels
   function automatic logic [15:0] draw_pixel();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {$urandom_range(0, 1) ? 5'h1F : 5'h00,
                    $urandom_range(0, 1) ? 6'h3F : 6'h00,
                    $urandom_range(0, 1) ? 5'h1F : 5'h00};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // Queue one expanded output row of five words
   function automatic void push_row(input logic [7:0] x0, input logic [7:0] y,
                                    input logic [4:0][15:0] colours, input logic mark_last);
      out_pixel_type w;
      for (int k = 0; k < 5; k++) begin
         w.x      = x0 + 8'(k);
         w.y      = y;
         w.colour = colours[k];
         w.last   = mark_last && (k == 4);
         pending_pixels.push_back(w);
      end
   endfunction

   // Work out the words one accepted source pixel produces
   function automatic void upscale_pixel(input logic [15:0] pix, input logic fixed_en,
                                         input logic [15:0] fixed_blend);
      logic [4:0][15:0] near_row;
      logic [4:0][15:0] far_row;
      logic [4:0][15:0] mid_row;
      logic [7:0]       x0;
      logic [7:0]       y0;
      logic             lower;
      lower = row_idx[0];
      if (!lower) upper_line[col_idx] = pix;
      if (!col_idx[0]) begin
         held_left = pix;
      end else begin
         x0 = 8'(5 * (col_idx >> 1));
         y0 = 8'(5 * (row_idx >> 1));
         near_row[0] = held_left;
         near_row[1] = held_left;
         near_row[2] = blend565(held_left, pix);
         near_row[3] = pix;
         near_row[4] = pix;
         if (!lower) begin
            if (fixed_en) near_row[2] = fixed_blend;
            push_row(x0, y0, near_row, 1'b0);
            push_row(x0, y0 + 8'd1, near_row, 1'b1);
         end else begin
            far_row[0] = upper_line[col_idx - 7'd1];
            far_row[1] = upper_line[col_idx - 7'd1];
            far_row[2] = blend565(upper_line[col_idx - 7'd1], upper_line[col_idx]);
            far_row[3] = upper_line[col_idx];
            far_row[4] = upper_line[col_idx];
            for (int k = 0; k < 5; k++)
               mid_row[k] = blend565(near_row[k], far_row[k]);
            push_row(x0, y0 + 8'd2, mid_row, 1'b0);
            push_row(x0, y0 + 8'd3, near_row, 1'b0);
            push_row(x0, y0 + 8'd4, near_row, 1'b1);
         end
      end
      // Advance the raster position, wrapping per row and per frame
      if (int'(col_idx) == SRC_W - 1) begin
         col_idx = '0;
         row_idx = (int'(row_idx) == SRC_H - 1) ? '0 : row_idx + 6'd1;
      end else begin
         col_idx = col_idx + 7'd1;
      end
   endfunction

   // Compare one accepted output word with the oldest expectation
   task automatic check_pixel_out();
      out_pixel_type w;
      words_seen++;
      if (pending_pixels.size() == 0) begin
         flag_mismatch($sformatf("unexpected word x=%0d y=%0d colour=%h",
                                 rsp_out_x, rsp_out_y, rsp_color_out));
         return;
      end
      w = pending_pixels.pop_front();
      if (rsp_out_x !== w.x)
         flag_mismatch($sformatf("out_x got %0d want %0d", rsp_out_x, w.x));
      if (rsp_out_y !== w.y)
         flag_mismatch($sformatf("out_y got %0d want %0d (x=%0d)", rsp_out_y, w.y, w.x));
      if (rsp_color_out !== w.colour)
         flag_mismatch($sformatf("colour got %h want %h at x=%0d y=%0d",
                                 rsp_color_out, w.colour, w.x, w.y));
      if (rsp_last_of_run !== w.last)
         flag_mismatch($sformatf("last_of_run got %b want %b at x=%0d y=%0d",
                                 rsp_last_of_run, w.last, w.x, w.y));
   endtask

   // Offer one source pixel after an idle gap and hold it until taken
   task automatic offer_pixel(input logic [15:0] pix, input int gap, input logic fixed_en,
                              input logic [15:0] fixed_blend);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      upscale_pixel(pix, fixed_en, fixed_blend);
   endtask

   // Result side: check accepted words and stall at random
   initial begin : result_side
      int stall_run;
      int hold_left;
      int next_hold_at;
      int cyc;
      stall_run    = 0;
      hold_left    = 0;
      next_hold_at = 600;
      cyc          = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (!reset && rsp_valid && !rsp_stall) check_pixel_out();
         // Hold off for a long stretch once, in the lower row, so the block backs up
         if (hold_left == 0 && words_seen >= next_hold_at) begin
            hold_left    = HOLD_LEN;
            next_hold_at = next_hold_at + 15000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if (((cyc / 1024) % 4) == 2) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_run = pick_gap();
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Source side: directed table, drain, then random pixels
   initial begin : source_side
      int gap;
      for (int i = 0; i < SRC_W; i++) upper_line[i] = '0;
      held_left = '0;
      col_idx   = '0;
      row_idx   = '0;

      // Extremes and carry cases on the first row; blend typed in where obvious
      directed_rows = '{
         '{16'h0000, 1'b0, 16'h0000}, '{16'hFFFF, 1'b1, 16'h7BEF},
         '{16'hFFFF, 1'b0, 16'h0000}, '{16'hFFFF, 1'b1, 16'hFFFF},
         '{16'h0821, 1'b0, 16'h0000}, '{16'h0821, 1'b1, 16'h0821},
         '{16'hF800, 1'b0, 16'h0000}, '{16'h0000, 1'b1, 16'h7800},
         '{16'h07E0, 1'b0, 16'h0000}, '{16'h07E0, 1'b1, 16'h07E0},
         '{16'h001F, 1'b0, 16'h0000}, '{16'h0000, 1'b1, 16'h000F},
         '{16'hFFFF, 1'b0, 16'h0000}, '{16'h0000, 1'b1, 16'h7BEF},
         '{16'h5555, 1'b0, 16'h0000}, '{16'hAAAA, 1'b0, 16'h0000},
         '{16'h8410, 1'b0, 16'h0000}, '{16'h7BEF, 1'b0, 16'h0000},
         '{16'h0001, 1'b0, 16'h0000}, '{16'h8000, 1'b0, 16'h0000},
         '{16'h1234, 1'b0, 16'h0000}, '{16'hFEDC, 1'b0, 16'h0000},
         '{16'hF81F, 1'b0, 16'h0000}, '{16'h07E0, 1'b0, 16'h0000}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         offer_pixel(directed_rows[i].pixel, (i % 5 == 3) ? pick_gap() : 0,
                     directed_rows[i].fixed_en, directed_rows[i].fixed_blend);

      // Pause until every expected word has come out
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         gap = (((i / 256) % 4) == 1) ? 0 : pick_gap();
         offer_pixel(draw_pixel(), gap, 1'b0, 16'h0000);
      end
      req_valid <= 1'b0;

      // Drain, then allow for any stray words
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
